>>> design/kdt_pkg.sv
// ----------------------------------------------------------------------------
// kdt_pkg
// Shared types and constants for the 2-D kd-tree build and nearest-query core.
// ----------------------------------------------------------------------------
package kdt_pkg;

   localparam int unsigned MAX_POINTS_DEF = 1024;
   localparam int unsigned COORD_BITS_DEF = 16;
   localparam int unsigned SLOT_BITS      = 10;
   localparam int unsigned COUNT_BITS     = 11;
   localparam int unsigned OP_BITS        = 2;

   localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_BUILD = 2'd1;
   localparam logic [OP_BITS-1:0] OP_QUERY = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RESULT,
      // build: insertion sort of one range, then split it
      ST_B_POP,
      ST_B_ILOAD,
      ST_B_IWAIT,
      ST_B_JREAD,
      ST_B_JWAIT,
      ST_B_JCMP,
      ST_B_IPUT,
      ST_B_SPLIT,
      // query walk
      ST_Q_POP,
      ST_Q_MREAD,
      ST_Q_MWAIT,
      ST_Q_SQ1,
      ST_Q_SQ2,
      ST_Q_ADD,
      ST_Q_FAR
   } state_type;

   // One pending range on the work stack.
   typedef struct packed {
      logic [SLOT_BITS+6:0] start;
      logic [SLOT_BITS+6:0] len;
      logic                 by_x;
      logic                 far_pend;
   } frame_type;

endpackage

>>> design/kd_tree_build_and_nearest_query_core.sv
// ----------------------------------------------------------------------------
// kd_tree_build_and_nearest_query_core
// Loads points, builds an implicit kd-tree in place, answers nearest queries.
// ----------------------------------------------------------------------------
// A load request passes through the result state, and the block takes the next
// request once that result is taken. A build request runs an insertion sort
// over every range of two or more points through one single-port point memory,
// one memory access per step, with a read, a read wait and a compare-and-shift
// step per shifted point. A query request walks the tree with one shared
// squaring unit. Every popped range that is not empty goes through pop, memory
// read, read wait, two squares, add and compare. A leaf is scored in one such
// pass. An inner node takes two passes, one to pick the near side and one to
// score its split point after the near side is done, plus one step to decide
// on its far side. An empty range is only popped. The block accepts one
// request at a time and holds its result in an output register until it is
// taken.
module kd_tree_build_and_nearest_query_core #(
   parameter int unsigned MAX_POINTS = kdt_pkg::MAX_POINTS_DEF,
   parameter int unsigned COORD_BITS = kdt_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [kdt_pkg::COUNT_BITS-1:0]        csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [kdt_pkg::OP_BITS-1:0]           req_op,
   input  logic [kdt_pkg::SLOT_BITS-1:0]         req_slot,
   input  logic signed [COORD_BITS-1:0]          req_x_coord,
   input  logic signed [COORD_BITS-1:0]          req_y_coord,
   input  logic [2*COORD_BITS:0]                 req_radius_sq,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [kdt_pkg::OP_BITS-1:0]           rsp_done_op,
   output logic                                  rsp_found,
   output logic [kdt_pkg::SLOT_BITS-1:0]         rsp_nearest_slot,
   output logic [2*COORD_BITS:0]                 rsp_best_dist_sq
);

   localparam int unsigned ABITS  = $clog2(MAX_POINTS);
   localparam int unsigned DBITS  = 2 * COORD_BITS + 1;
   localparam int unsigned DEPTH  = ABITS + 2;
   localparam int unsigned SPBITS = $clog2(DEPTH + 1);
   localparam int unsigned IBITS  = ABITS + 1;
   localparam int unsigned FW     = kdt_pkg::SLOT_BITS + 7;

   typedef logic [2*COORD_BITS-1:0] pt_type;

   // point memory
   pt_type             mem [MAX_POINTS];
   logic [ABITS-1:0]   mem_addr;
   logic               mem_we;
   pt_type             mem_wdata;
   pt_type             mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_addr];
   end

   // work stack
   kdt_pkg::frame_type stk_ff [DEPTH];
   logic [SPBITS-1:0]  sp_ff, sp_in;

   kdt_pkg::state_type state_ff, state_in;
   logic [kdt_pkg::COUNT_BITS-1:0] count_ff;

   // request registers
   logic [kdt_pkg::OP_BITS-1:0]  op_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic [DBITS-1:0]             best_ff, best_in;
   logic [ABITS-1:0]             bslot_ff, bslot_in;
   logic                         found_ff, found_in;

   // current frame / sort indices
   logic [IBITS-1:0]   cs_ff, cs_in, cl_ff, cl_in;
   logic               cx_ff, cx_in;
   logic               second_ff, second_in;
   logic [IBITS-1:0]   i_ff, i_in, j_ff, j_in;
   pt_type             hold_ff, hold_in;

   // squaring unit
   logic signed [COORD_BITS:0] sd_ff, sd_in;
   logic [COORD_BITS:0]        mag;
   logic [2*COORD_BITS+1:0]    sq;
   logic [2*COORD_BITS+1:0]    sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic signed [COORD_BITS:0] dy_ff, dy_in;
   logic [2*COORD_BITS+2:0]    sum;
   logic [DBITS-1:0]           cand_dist;

   // result register
   logic                          rv_ff;
   logic [kdt_pkg::OP_BITS-1:0]   rop_ff;
   logic                          rfound_ff;
   logic [kdt_pkg::SLOT_BITS-1:0] rslot_ff;
   logic [DBITS-1:0]              rdist_ff;
   logic                          finish;

   // stack push/pop requests
   logic                 push_a, push_b, pop;
   kdt_pkg::frame_type   fa, fb;

   logic [IBITS-1:0] used;
   assign used = (count_ff > kdt_pkg::COUNT_BITS'(MAX_POINTS)) ?
                 IBITS'(MAX_POINTS) : IBITS'(count_ff);

   logic accept;
   assign req_stall = (state_ff != kdt_pkg::ST_IDLE) || rv_ff;
   assign accept    = req_valid && !req_stall;

   kdt_pkg::frame_type top;
   assign top = stk_ff[SPBITS'(sp_ff - 1'b1)];

   function automatic logic signed [COORD_BITS-1:0] key(pt_type p, logic bx);
      return bx ? p[2*COORD_BITS-1:COORD_BITS] : p[COORD_BITS-1:0];
   endfunction

   assign mag = sd_ff[COORD_BITS] ? (COORD_BITS+1)'(-sd_ff) : sd_ff;
   assign sq  = mag * mag;
   assign sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign cand_dist = (sum > (2*COORD_BITS+3)'({DBITS{1'b1}})) ?
                      {DBITS{1'b1}} : sum[DBITS-1:0];

   logic [IBITS-1:0] half, mid;
   assign half = cl_ff >> 1;
   assign mid  = cs_ff + half;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kdt_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_op == kdt_pkg::OP_BUILD) begin
                  state_in = kdt_pkg::ST_B_POP;
               end else if (req_op == kdt_pkg::OP_QUERY) begin
                  state_in = kdt_pkg::ST_Q_POP;
               end else begin
                  state_in = kdt_pkg::ST_RESULT;
               end
            end
         end
         kdt_pkg::ST_RESULT: state_in = kdt_pkg::ST_IDLE;
         kdt_pkg::ST_B_POP: begin
            if (sp_ff == '0) begin
               state_in = kdt_pkg::ST_RESULT;
            end else if (top.len <= FW'(1)) begin
               state_in = kdt_pkg::ST_B_POP;
            end else begin
               state_in = kdt_pkg::ST_B_ILOAD;
            end
         end
         kdt_pkg::ST_B_ILOAD: begin
            state_in = (i_ff >= cl_ff) ? kdt_pkg::ST_B_SPLIT : kdt_pkg::ST_B_IWAIT;
         end
         kdt_pkg::ST_B_IWAIT: state_in = kdt_pkg::ST_B_JREAD;
         kdt_pkg::ST_B_JREAD: begin
            state_in = (j_ff == '0) ? kdt_pkg::ST_B_IPUT : kdt_pkg::ST_B_JWAIT;
         end
         kdt_pkg::ST_B_JWAIT: state_in = kdt_pkg::ST_B_JCMP;
         kdt_pkg::ST_B_JCMP: begin
            state_in = (key(mem_rdata_ff, cx_ff) > key(hold_ff, cx_ff)) ?
                       kdt_pkg::ST_B_JREAD : kdt_pkg::ST_B_IPUT;
         end
         kdt_pkg::ST_B_IPUT:  state_in = kdt_pkg::ST_B_ILOAD;
         kdt_pkg::ST_B_SPLIT: state_in = kdt_pkg::ST_B_POP;
         kdt_pkg::ST_Q_POP: begin
            if (sp_ff == '0) begin
               state_in = kdt_pkg::ST_RESULT;
            end else if (top.len == '0) begin
               state_in = kdt_pkg::ST_Q_POP;
            end else begin
               state_in = kdt_pkg::ST_Q_MREAD;
            end
         end
         kdt_pkg::ST_Q_MREAD: state_in = kdt_pkg::ST_Q_MWAIT;
         kdt_pkg::ST_Q_MWAIT: state_in = kdt_pkg::ST_Q_SQ1;
         kdt_pkg::ST_Q_SQ1:   state_in = kdt_pkg::ST_Q_SQ2;
         kdt_pkg::ST_Q_SQ2:   state_in = kdt_pkg::ST_Q_ADD;
         kdt_pkg::ST_Q_ADD: begin
            state_in = (second_ff && cl_ff != IBITS'(1)) ?
                       kdt_pkg::ST_Q_FAR : kdt_pkg::ST_Q_POP;
         end
         kdt_pkg::ST_Q_FAR:   state_in = kdt_pkg::ST_Q_POP;
         default:             state_in = kdt_pkg::ST_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = cs_ff[ABITS-1:0];
      mem_wdata = hold_ff;
      cs_in = cs_ff; cl_in = cl_ff; cx_in = cx_ff; second_in = second_ff;
      i_in = i_ff; j_in = j_ff; hold_in = hold_ff;
      sd_in = sd_ff; dy_in = dy_ff; sqx_in = sqx_ff; sqy_in = sqy_ff;
      best_in = best_ff; bslot_in = bslot_ff; found_in = found_ff;
      push_a = 1'b0; push_b = 1'b0; pop = 1'b0;
      fa = '0; fb = '0;
      finish = 1'b0;
      case (state_ff)
         kdt_pkg::ST_IDLE: begin
            mem_addr  = req_slot[ABITS-1:0];
            mem_wdata = {req_x_coord, req_y_coord};
            if (accept) begin
               mem_we = (req_op == kdt_pkg::OP_LOAD) &&
                        (32'(req_slot) < MAX_POINTS);
               best_in  = req_radius_sq;
               bslot_in = '0;
               found_in = 1'b0;
               if (req_op == kdt_pkg::OP_BUILD || req_op == kdt_pkg::OP_QUERY) begin
                  push_a = 1'b1;
                  fa.start = '0;
                  fa.len = FW'(used);
                  fa.by_x = 1'b1;
               end
            end
         end
         kdt_pkg::ST_RESULT: finish = 1'b1;
         kdt_pkg::ST_B_POP: begin
            if (sp_ff != '0) begin
               pop = 1'b1;
               cs_in = IBITS'(top.start);
               cl_in = IBITS'(top.len);
               cx_in = top.by_x;
               i_in  = IBITS'(1);
            end
         end
         kdt_pkg::ST_B_ILOAD: begin
            mem_addr = ABITS'(cs_ff + i_ff);
            j_in = i_ff;
         end
         kdt_pkg::ST_B_IWAIT: hold_in = mem_rdata_ff;
         kdt_pkg::ST_B_JREAD: begin
            mem_addr = ABITS'(cs_ff + j_ff - 1'b1);
         end
         kdt_pkg::ST_B_JWAIT: begin
            mem_addr = ABITS'(cs_ff + j_ff - 1'b1);
         end
         kdt_pkg::ST_B_JCMP: begin
            if (key(mem_rdata_ff, cx_ff) > key(hold_ff, cx_ff)) begin
               mem_we = 1'b1;
               mem_addr = ABITS'(cs_ff + j_ff);
               mem_wdata = mem_rdata_ff;
               j_in = j_ff - 1'b1;
            end
         end
         kdt_pkg::ST_B_IPUT: begin
            mem_we = 1'b1;
            mem_addr = ABITS'(cs_ff + j_ff);
            mem_wdata = hold_ff;
            i_in = i_ff + 1'b1;
         end
         kdt_pkg::ST_B_SPLIT: begin
            push_a = 1'b1;
            fa.start = FW'(cs_ff);
            fa.len = FW'(half);
            fa.by_x = !cx_ff;
            push_b = 1'b1;
            fb.start = FW'(mid + 1'b1);
            fb.len = FW'(cl_ff - half - 1'b1);
            fb.by_x = !cx_ff;
         end
         kdt_pkg::ST_Q_POP: begin
            if (sp_ff != '0) begin
               pop = 1'b1;
               cs_in = IBITS'(top.start);
               cl_in = IBITS'(top.len);
               cx_in = top.by_x;
               second_in = top.far_pend;
            end
         end
         kdt_pkg::ST_Q_MREAD: mem_addr = (cl_ff == IBITS'(1)) ? cs_ff[ABITS-1:0] : mid[ABITS-1:0];
         kdt_pkg::ST_Q_MWAIT: begin
            sd_in = (COORD_BITS+1)'(key(mem_rdata_ff, cx_ff)) -
                    (COORD_BITS+1)'(cx_ff ? px_ff : py_ff);
            // the other axis, for the distance
            dy_in = (COORD_BITS+1)'(key(mem_rdata_ff, !cx_ff)) -
                    (COORD_BITS+1)'(cx_ff ? py_ff : px_ff);
         end
         kdt_pkg::ST_Q_SQ1: begin
            sqx_in = sq;
            sd_in = dy_ff;
            dy_in = sd_ff;
         end
         kdt_pkg::ST_Q_SQ2: begin
            sqy_in = sq;
            sd_in = dy_ff;
         end
         kdt_pkg::ST_Q_ADD: begin
            if (cl_ff == IBITS'(1) || second_ff) begin
               if (cand_dist < best_ff) begin
                  best_in = cand_dist;
                  bslot_in = (cl_ff == IBITS'(1)) ? cs_ff[ABITS-1:0] : mid[ABITS-1:0];
                  found_in = 1'b1;
               end
            end else begin
               // The node waits below its near side; its split point is scored
               // and its far side decided once the near side is done.
               push_a = 1'b1;
               fa.start = FW'(cs_ff);
               fa.len = FW'(cl_ff);
               fa.by_x = cx_ff;
               fa.far_pend = 1'b1;
               push_b = 1'b1;
               if (sd_ff[COORD_BITS]) begin
                  fb.start = FW'(mid + 1'b1);
                  fb.len = FW'(cl_ff - half - 1'b1);
               end else begin
                  fb.start = FW'(cs_ff);
                  fb.len = FW'(half);
               end
               fb.by_x = !cx_ff;
            end
         end
         kdt_pkg::ST_Q_FAR: begin
            // far side kept only when the plane is closer than the best
            if (sqx_ff < {1'b0, best_ff}) begin
               push_a = 1'b1;
               if (sd_ff[COORD_BITS]) begin
                  fa.start = FW'(cs_ff);
                  fa.len = FW'(half);
               end else begin
                  fa.start = FW'(mid + 1'b1);
                  fa.len = FW'(cl_ff - half - 1'b1);
               end
               fa.by_x = !cx_ff;
            end
         end
         default: ;
      endcase
   end

   // stack update
   always_comb begin
      sp_in = sp_ff;
      if (pop) begin
         sp_in = sp_ff - 1'b1;
      end
      if (push_a) begin
         sp_in = sp_in + 1'b1;
      end
      if (push_b) begin
         sp_in = sp_in + 1'b1;
      end
   end

   logic [SPBITS-1:0] base;
   assign base = pop ? SPBITS'(sp_ff - 1'b1) : sp_ff;

   always_ff @(posedge clock) begin
      if (push_a) begin
         stk_ff[base] <= fa;
      end
      if (push_b) begin
         stk_ff[SPBITS'(base + (push_a ? 1'b1 : 1'b0))] <= fb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kdt_pkg::ST_IDLE;
         sp_ff    <= '0;
         count_ff <= '0;
         rv_ff    <= 1'b0;
         best_ff  <= '0;
         bslot_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         if (csr_write) begin
            count_ff <= csr_wdata;
         end
         best_ff  <= best_in;
         bslot_ff <= bslot_in;
         found_ff <= found_in;
         if (finish) begin
            rv_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cs_ff <= cs_in; cl_ff <= cl_in; cx_ff <= cx_in; second_ff <= second_in;
      i_ff <= i_in; j_ff <= j_in; hold_ff <= hold_in;
      sd_ff <= sd_in; dy_ff <= dy_in; sqx_ff <= sqx_in; sqy_ff <= sqy_in;
      if (accept) begin
         op_ff <= req_op;
         px_ff <= req_x_coord;
         py_ff <= req_y_coord;
      end
      if (finish) begin
         rop_ff <= op_ff;
         if (op_ff == kdt_pkg::OP_QUERY) begin
            rfound_ff <= found_ff;
            rslot_ff  <= kdt_pkg::SLOT_BITS'(bslot_ff);
            rdist_ff  <= best_ff;
         end else begin
            rfound_ff <= 1'b0;
            rslot_ff  <= '0;
            rdist_ff  <= '0;
         end
      end
   end

   assign rsp_valid        = rv_ff;
   assign rsp_done_op      = rop_ff;
   assign rsp_found        = rfound_ff;
   assign rsp_nearest_slot = rslot_ff;
   assign rsp_best_dist_sq = rdist_ff;

endmodule

>>> design/kdt_checker.sv
// ----------------------------------------------------------------------------
// kdt_checker
// Port-level checks of the kd-tree core, bound to the top level.
// ----------------------------------------------------------------------------
module kdt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [kdt_pkg::OP_BITS-1:0]   rsp_done_op,
   input logic                          rsp_found
);

   // A result waiting to be taken blocks new requests.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while result pending");

   // A stalled result stays.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_done_op))
      else $error("stalled result changed");

   // Only queries report a hit.
   a_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_done_op == kdt_pkg::OP_QUERY)
      else $error("hit on non-query result");

   // An accepted request makes the block busy next cycle.
   a_acc: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("not busy after request");

endmodule

bind kd_tree_build_and_nearest_query_core kdt_checker u_kdt_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_done_op(rsp_done_op),
   .rsp_found(rsp_found)
);

>>> test/tb_kd_tree_build_and_nearest_query_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kd_tree_build_and_nearest_query_core
// Self-checking bench: loads points, builds the tree and runs nearest queries
// over a range of point counts, predicting every response in a scoreboard.
// ----------------------------------------------------------------------------
module tb_kd_tree_build_and_nearest_query_core;

   localparam logic [kdt_pkg::OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam logic [32:0]                 RADIUS_MAX = {33{1'b1}};

   typedef struct packed {
      logic [kdt_pkg::OP_BITS-1:0]   op;
      logic                          found;
      logic [kdt_pkg::SLOT_BITS-1:0] slot;
      logic [32:0]                   dist_sq;
   } outcome_type;

   class kd_scoreboard;
      int                  px[kdt_pkg::MAX_POINTS_DEF];
      int                  py[kdt_pkg::MAX_POINTS_DEF];
      int unsigned         point_count;
      outcome_type         awaited[$];
      int                  errors;
      int                  probe_x, probe_y;
      longint unsigned     walk_best;
      int unsigned         walk_slot;
      bit                  walk_found;

      function void set_count(logic [kdt_pkg::COUNT_BITS-1:0] value);
         point_count = value;
      endfunction

      function int unsigned used_count();
         return point_count > kdt_pkg::MAX_POINTS_DEF ? kdt_pkg::MAX_POINTS_DEF : point_count;
      endfunction

      function longint unsigned dist_to(int idx);
         longint dx, dy;
         longint unsigned sum;
         dx = px[idx] - probe_x;
         dy = py[idx] - probe_y;
         sum = dx * dx + dy * dy;
         if (sum > RADIUS_MAX) sum = RADIUS_MAX;
         return sum;
      endfunction

      function void sort_range(int start, int len, bit by_x);
         int hx, hy, k, j;
         for (int i = 1; i < len; i++) begin
            hx = px[start + i];
            hy = py[start + i];
            k = by_x ? hx : hy;
            j = i;
            while (j > 0 && (by_x ? px[start + j - 1] : py[start + j - 1]) > k) begin
               px[start + j] = px[start + j - 1];
               py[start + j] = py[start + j - 1];
               j--;
            end
            px[start + j] = hx;
            py[start + j] = hy;
         end
      endfunction

      function void build_range(int start, int len, bit by_x);
         int half;
         if (len <= 1) return;
         sort_range(start, len, by_x);
         half = len / 2;
         build_range(start, half, !by_x);
         build_range(start + half + 1, len - half - 1, !by_x);
      endfunction

      function void visit(int idx);
         longint unsigned d;
         d = dist_to(idx);
         if (d < walk_best) begin
            walk_best = d;
            walk_slot = idx;
            walk_found = 1;
         end
      endfunction

      function void walk(int start, int len, bit by_x);
         int half, mid, ns, nl, fs, fl;
         longint sd;
         longint unsigned m;
         if (len == 0) return;
         if (len == 1) begin
            visit(start);
            return;
         end
         half = len / 2;
         mid = start + half;
         sd = by_x ? px[mid] - probe_x : py[mid] - probe_y;
         ns = start; nl = half; fs = mid + 1; fl = len - half - 1;
         if (sd < 0) begin
            ns = mid + 1; nl = len - half - 1; fs = start; fl = half;
         end
         walk(ns, nl, !by_x);
         visit(mid);
         m = sd < 0 ? -sd : sd;
         if (m * m < walk_best) walk(fs, fl, !by_x);
      endfunction

      function void note_request(logic [kdt_pkg::OP_BITS-1:0] op,
                                 logic [kdt_pkg::SLOT_BITS-1:0] slot,
                                 logic signed [15:0] x, logic signed [15:0] y,
                                 logic [32:0] radius);
         outcome_type o;
         o = '{op, 1'b0, '0, '0};
         case (op)
            kdt_pkg::OP_LOAD: begin
               px[slot] = x;
               py[slot] = y;
            end
            kdt_pkg::OP_BUILD: build_range(0, used_count(), 1'b1);
            kdt_pkg::OP_QUERY: begin
               probe_x = x;
               probe_y = y;
               walk_best = radius;
               walk_slot = 0;
               walk_found = 0;
               walk(0, used_count(), 1'b1);
               o.found = walk_found;
               o.slot = kdt_pkg::SLOT_BITS'(walk_slot);
               o.dist_sq = 33'(walk_best);
            end
            default: ;
         endcase
         awaited.push_back(o);
      endfunction

      function void check_result(outcome_type got);
         outcome_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response op=%0d", got.op);
            return;
         end
         want = awaited.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display("mismatch exp op=%0d f=%0d slot=%0d d=%0d got op=%0d f=%0d slot=%0d d=%0d",
                        want.op, want.found, want.slot, want.dist_sq,
                        got.op, got.found, got.slot, got.dist_sq);
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_write = 1'b0;
   logic [kdt_pkg::COUNT_BITS-1:0] csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [kdt_pkg::OP_BITS-1:0]   req_op = '0;
   logic [kdt_pkg::SLOT_BITS-1:0] req_slot = '0;
   logic signed [15:0]            req_x_coord = '0;
   logic signed [15:0]            req_y_coord = '0;
   logic [32:0]                   req_radius_sq = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [kdt_pkg::OP_BITS-1:0]   rsp_done_op;
   logic                          rsp_found;
   logic [kdt_pkg::SLOT_BITS-1:0] rsp_nearest_slot;
   logic [32:0]                   rsp_best_dist_sq;

   kd_scoreboard sb = new();
   bit           loaded[kdt_pkg::MAX_POINTS_DEF];
   bit           quiet;
   bit           hold_off;
   int           items_sent;

   kd_tree_build_and_nearest_query_core dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_op(req_op),
      .req_slot(req_slot), .req_x_coord(req_x_coord), .req_y_coord(req_y_coord),
      .req_radius_sq(req_radius_sq),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_done_op(rsp_done_op),
      .rsp_found(rsp_found), .rsp_nearest_slot(rsp_nearest_slot),
      .rsp_best_dist_sq(rsp_best_dist_sq)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Signals read right after the edge still hold their pre-edge values.
   always @(posedge clock) begin : receiver
      static int stall_left = 0;
      static int r;
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_done_op, rsp_found, rsp_nearest_slot, rsp_best_dist_sq});
      if (hold_off) begin
         // Long hold-off so that a result waits and the core stalls its input.
         stall_left = 300;
         hold_off = 0;
      end else if (stall_left == 0 && !quiet) begin
         r = $urandom_range(0, 99);
         if (r >= 60) stall_left = r < 95 ? $urandom_range(1, 3) : $urandom_range(15, 60);
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_request(logic [kdt_pkg::OP_BITS-1:0] op,
                               logic [kdt_pkg::SLOT_BITS-1:0] slot,
                               logic signed [15:0] x, logic signed [15:0] y,
                               logic [32:0] radius);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_slot <= slot;
      req_x_coord <= x;
      req_y_coord <= y;
      req_radius_sq <= radius;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, slot, x, y, radius);
      if (op == kdt_pkg::OP_LOAD) loaded[slot] = 1;
      items_sent++;
   endtask

   task automatic load_point(int slot, logic signed [15:0] x, logic signed [15:0] y);
      send_request(kdt_pkg::OP_LOAD, kdt_pkg::SLOT_BITS'(slot), x, y, '0);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_count(int unsigned value);
      wait_idle();
      csr_write <= 1'b1;
      csr_wdata <= kdt_pkg::COUNT_BITS'(value);
      @(posedge clock);
      csr_write <= 1'b0;
      sb.set_count(kdt_pkg::COUNT_BITS'(value));
   endtask

   function automatic logic signed [15:0] rand_coord();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return $signed(16'($urandom_range(0, 8))) - 16'sd4;
      if (r < 45) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      return 16'($urandom);
   endfunction

   function automatic logic [32:0] rand_radius();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return RADIUS_MAX;
      if (r < 55) return '0;
      if (r < 80) return 33'($urandom_range(0, 200));
      return {1'($urandom), 32'($urandom)};
   endfunction

   task automatic run_phase(int unsigned count, int n);
      int unsigned used;
      int r;
      write_count(count);
      used = count > kdt_pkg::MAX_POINTS_DEF ? kdt_pkg::MAX_POINTS_DEF : count;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (used > 64) begin
            // Too many points to build here; loads and unused ops only, so no empty entry is read.
            if (r < 90) load_point($urandom_range(0, 1023), rand_coord(), rand_coord());
            else send_request(OP_UNUSED, 10'($urandom), 16'($urandom), 16'($urandom),
                              {1'($urandom), 32'($urandom)});
            continue;
         end
         for (int s = 0; s < used; s++)
            if (!loaded[s]) load_point(s, rand_coord(), rand_coord());
         if (r < 12)
            load_point(used > 0 && r < 8 ? $urandom_range(0, used - 1)
                       : $urandom_range(0, 1023), rand_coord(), rand_coord());
         else if (r < 27) send_request(kdt_pkg::OP_BUILD, 10'($urandom), 16'($urandom),
                                       16'($urandom), {1'($urandom), 32'($urandom)});
         else if (r < 96) send_request(kdt_pkg::OP_QUERY, 10'($urandom), rand_coord(),
                                       rand_coord(), rand_radius());
         else send_request(OP_UNUSED, 10'($urandom), 16'($urandom), 16'($urandom),
                           {1'($urandom), 32'($urandom)});
      end
   endtask

   initial begin
      int unsigned count;
      int r;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Empty tree, unused op and the extreme store positions.
      write_count(0);
      send_request(kdt_pkg::OP_QUERY, '0, 16'sd5, -16'sd5, 33'd12345);
      send_request(kdt_pkg::OP_BUILD, '0, '0, '0, '0);
      send_request(OP_UNUSED, 10'h3ff, 16'sh7fff, 16'sh8000, RADIUS_MAX);
      load_point(1023, 16'sh7fff, 16'sh8000);
      load_point(0, 16'sh8000, 16'sh7fff);
      load_point(1, 16'sh7fff, 16'sh8000);
      write_count(2);
      send_request(kdt_pkg::OP_QUERY, '0, 16'sh8000, 16'sh8000, RADIUS_MAX);
      send_request(kdt_pkg::OP_QUERY, '0, 16'sh7fff, 16'sh7fff, '0);
      send_request(kdt_pkg::OP_BUILD, '0, '0, '0, '0);
      send_request(kdt_pkg::OP_QUERY, '0, 16'sh7fff, 16'sh8000, RADIUS_MAX);

      // Equal keys and equal distances.
      write_count(5);
      load_point(2, 16'sd3, 16'sd1);
      load_point(3, 16'sd3, -16'sd1);
      load_point(4, 16'sd3, 16'sd1);
      load_point(0, 16'sd3, 16'sd0);
      load_point(1, 16'sd1, 16'sd0);
      send_request(kdt_pkg::OP_BUILD, '0, '0, '0, '0);
      send_request(kdt_pkg::OP_QUERY, '0, 16'sd2, 16'sd0, RADIUS_MAX);
      send_request(kdt_pkg::OP_QUERY, '0, 16'sd3, 16'sd1, 33'd1);
      send_request(kdt_pkg::OP_QUERY, '0, 16'sd3, 16'sd0, 33'd2);

      // Counts at and beyond the store size: loads and unused ops only.
      run_phase(2047, 12);
      run_phase(1024, 12);

      quiet = 1;
      run_phase(6, 20);
      quiet = 0;
      hold_off = 1;
      run_phase(12, 30);

      while (items_sent < 650) begin
         r = $urandom_range(0, 99);
         if (r < 8) count = 0;
         else if (r < 16) count = 1;
         else if (r < 26) count = $urandom_range(2, 3);
         else if (r < 92) count = $urandom_range(4, 32);
         else count = $urandom_range(48, 64);
         run_phase(count, 30);
      end

      wait_idle();
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
design/kdt_pkg.sv
design/kd_tree_build_and_nearest_query_core.sv
design/kdt_checker.sv
test/tb_kd_tree_build_and_nearest_query_core.sv
